// ===== src/tracked_byte_memory_macros.svh =====
// Assertion macros shared by the tracked byte memory modules.
`ifndef TRACKED_BYTE_MEMORY_MACROS_SVH
`define TRACKED_BYTE_MEMORY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tbm_pkg.sv =====
package tbm_pkg;

	localparam int unsigned TbmAddrBitsDef = 16;
	localparam int unsigned TbmAddrBitsMax = 24;

	typedef enum logic [3:0] {
		KIND_RD_BYTE   = 4'd0,
		KIND_RD_WORD   = 4'd1,
		KIND_RD_DWORD  = 4'd2,
		KIND_WR_BYTE   = 4'd3,
		KIND_WR_WORD   = 4'd4,
		KIND_WR_DWORD  = 4'd5,
		KIND_FL_BYTE   = 4'd6,
		KIND_FL_WORD   = 4'd7,
		KIND_FL_DWORD  = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_READ,
		OP_WRITE,
		OP_FILL
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] size_m1;
	} kind_dec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_DONE
	} ctrl_state_t;

	function automatic kind_dec_t decode_kind(logic [3:0] kind);
		kind_dec_t d;
		d.op = OP_NONE;
		d.size_m1 = 2'd0;
		case (kind_t'(kind))
			KIND_RD_BYTE: begin
				d.op = OP_READ;
				d.size_m1 = 2'd0;
			end
			KIND_RD_WORD: begin
				d.op = OP_READ;
				d.size_m1 = 2'd1;
			end
			KIND_RD_DWORD: begin
				d.op = OP_READ;
				d.size_m1 = 2'd3;
			end
			KIND_WR_BYTE: begin
				d.op = OP_WRITE;
				d.size_m1 = 2'd0;
			end
			KIND_WR_WORD: begin
				d.op = OP_WRITE;
				d.size_m1 = 2'd1;
			end
			KIND_WR_DWORD: begin
				d.op = OP_WRITE;
				d.size_m1 = 2'd3;
			end
			KIND_FL_BYTE: begin
				d.op = OP_FILL;
				d.size_m1 = 2'd0;
			end
			KIND_FL_WORD: begin
				d.op = OP_FILL;
				d.size_m1 = 2'd1;
			end
			KIND_FL_DWORD: begin
				d.op = OP_FILL;
				d.size_m1 = 2'd3;
			end
			default: begin
				d.op = OP_NONE;
				d.size_m1 = 2'd0;
			end
		endcase
		return d;
	endfunction

endpackage

// ===== src/tbm_store.sv =====
module tbm_store #(
	parameter int unsigned ADDR_BITS = tbm_pkg::TbmAddrBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	output logic                 busy,
	input  logic                 wr_en,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [7:0]           wdata,
	output logic [7:0]           rdata
);
	import tbm_pkg::*;

	localparam int unsigned Depth = 2 ** ADDR_BITS;

	logic [7:0]           mem [Depth];
	logic [ADDR_BITS-1:0] clr_addr_q;
	logic                 busy_q;
	logic [7:0]           rdata_q;

	// After reset every byte is written with zero, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= 8'h00;
		end else if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign busy = busy_q;
	assign rdata = rdata_q;

endmodule

// ===== src/tbm_marks.sv =====
`include "tracked_byte_memory_macros.svh"

module tbm_marks #(
	parameter int unsigned ADDR_BITS = tbm_pkg::TbmAddrBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 touch_en,
	input  logic [ADDR_BITS-1:0] touch_addr,
	output logic [ADDR_BITS-1:0] mark_lo,
	output logic [ADDR_BITS-1:0] mark_hi
);
	import tbm_pkg::*;

	logic [ADDR_BITS-1:0] low_q;
	logic [ADDR_BITS-1:0] high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '1;
			high_q <= '0;
		end else if (touch_en) begin
			if (touch_addr < low_q) begin
				low_q <= touch_addr;
			end
			if (touch_addr > high_q) begin
				high_q <= touch_addr;
			end
		end
	end

	assign mark_lo = low_q;
	assign mark_hi = high_q;

	`TBM_ASSERT_NEXT(a_marks_cover_touch, clk, arst_n, touch_en, (low_q <= $past(touch_addr)) && (high_q >= $past(touch_addr)), "Marks do not cover the touched byte.")

endmodule

// ===== src/tbm_ctrl.sv =====
`include "tracked_byte_memory_macros.svh"

module tbm_ctrl #(
	parameter int unsigned ADDR_BITS = tbm_pkg::TbmAddrBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3:0]           in_kind,
	input  logic [15:0]          in_address,
	input  logic [31:0]          in_value,
	input  logic [15:0]          in_count,
	output logic                 res_valid,
	input  logic                 res_take,
	output logic [31:0]          res_rdata,
	input  logic                 mem_busy,
	output logic                 mem_wr_en,
	output logic                 mem_rd_en,
	output logic [ADDR_BITS-1:0] mem_addr,
	output logic [7:0]           mem_wdata,
	input  logic [7:0]           mem_rdata,
	output logic                 touch_en,
	output logic [ADDR_BITS-1:0] touch_addr
);
	import tbm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	op_t                  op_q;
	logic [1:0]           size_m1_q;
	logic [1:0]           lane_q;
	logic [15:0]          elem_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [31:0]          value_q;
	logic [31:0]          rdata_q;
	logic                 rd_pend_q;
	logic [1:0]           rd_lane_q;

	kind_dec_t                 dec;
	logic                      accept;
	logic                      skip;
	logic                      last_byte;
	logic [TbmAddrBitsMax-1:0] addr_wide;

	assign dec = decode_kind(in_kind);
	assign accept = in_valid && in_ready;
	assign skip = (dec.op == OP_NONE) || ((dec.op == OP_FILL) && (in_count == 16'd0));
	assign last_byte = (lane_q == size_m1_q) && (elem_q == 16'd1);
	assign addr_wide = TbmAddrBitsMax'(in_address);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = skip ? ST_DONE : ST_STEP;
				end
			end
			ST_STEP: begin
				if (last_byte) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		res_valid = 1'b0;
		mem_wr_en = 1'b0;
		mem_rd_en = 1'b0;
		touch_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !mem_busy;
			end
			ST_STEP: begin
				touch_en = 1'b1;
				mem_rd_en = (op_q == OP_READ);
				mem_wr_en = (op_q != OP_READ);
			end
			ST_DONE: begin
				res_valid = !rd_pend_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign mem_addr = addr_q;
	assign touch_addr = addr_q;
	assign mem_wdata = 8'(value_q >> {lane_q, 3'b000});
	assign res_rdata = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_pend_q <= mem_rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			rdata_q[{rd_lane_q, 3'b000} +: 8] <= mem_rdata;
		end
		if (accept) begin
			op_q <= dec.op;
			size_m1_q <= dec.size_m1;
			lane_q <= 2'd0;
			elem_q <= (dec.op == OP_FILL) ? in_count : 16'd1;
			addr_q <= addr_wide[ADDR_BITS-1:0];
			value_q <= in_value;
			rdata_q <= 32'h0;
		end else if (state_q == ST_STEP) begin
			rd_lane_q <= lane_q;
			addr_q <= addr_q + 1'b1;
			if (lane_q == size_m1_q) begin
				lane_q <= 2'd0;
				elem_q <= elem_q - 16'd1;
			end else begin
				lane_q <= lane_q + 2'd1;
			end
		end
	end

	`TBM_ASSERT_SAME(a_no_access_while_clearing, clk, arst_n, mem_busy, !(mem_wr_en || mem_rd_en), "Store accessed during the clearing pass.")
	`TBM_ASSERT_SAME(a_step_has_elements, clk, arst_n, state_q == ST_STEP, elem_q != 16'd0, "Byte step with no element left.")

endmodule

// ===== src/tracked_byte_memory.sv =====
// Byte-addressed store of 2**ADDR_BITS bytes with byte, word and dword reads and writes
// (little-endian, addresses wrap) and fills of fill_count elements spaced one element
// size apart; every touched byte moves a low and a high watermark, and each request
// returns the read data, both marks and the touched span. After reset the store is
// cleared with a pass over every byte, during which no request is taken. The
// single-port byte store then does one byte per cycle. A request passes from idle
// through one step per touched byte (none for an unused kind or a fill of zero
// elements) to done, where a read also waits for its last byte; its result then moves
// into the output register once that is free, and only then is a new request taken. The next
// request may be taken while the previous result still waits at the output.
module tracked_byte_memory #(
	parameter int unsigned ADDR_BITS = tbm_pkg::TbmAddrBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// address[15:0], write_value[47:16], fill_count[63:48]
	input  logic [63:0] s_axis_tdata,
	// kind[3:0]
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[31:0], mark_lo[47:32], mark_hi[63:48], touched_span[79:64]
	output logic [79:0] m_axis_tdata
);
	import tbm_pkg::*;

	logic                      res_valid;
	logic                      res_take;
	logic [31:0]               res_rdata;
	logic                      mem_busy;
	logic                      mem_wr_en;
	logic                      mem_rd_en;
	logic [ADDR_BITS-1:0]      mem_addr;
	logic [7:0]                mem_wdata;
	logic [7:0]                mem_rdata;
	logic                      touch_en;
	logic [ADDR_BITS-1:0]      touch_addr;
	logic [ADDR_BITS-1:0]      mark_lo;
	logic [ADDR_BITS-1:0]      mark_hi;
	logic [TbmAddrBitsMax-1:0] low_wide;
	logic [TbmAddrBitsMax-1:0] high_wide;
	logic [15:0]               span;
	logic                      out_valid_q;
	logic [79:0]               out_data_q;

	tbm_ctrl #(
		.ADDR_BITS(ADDR_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (s_axis_tuser),
		.in_address (s_axis_tdata[15:0]),
		.in_value   (s_axis_tdata[47:16]),
		.in_count   (s_axis_tdata[63:48]),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res_rdata  (res_rdata),
		.mem_busy   (mem_busy),
		.mem_wr_en  (mem_wr_en),
		.mem_rd_en  (mem_rd_en),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.touch_en   (touch_en),
		.touch_addr (touch_addr)
	);

	tbm_store #(
		.ADDR_BITS(ADDR_BITS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (mem_busy),
		.wr_en  (mem_wr_en),
		.rd_en  (mem_rd_en),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	tbm_marks #(
		.ADDR_BITS(ADDR_BITS)
	) u_marks (
		.clk        (clk),
		.arst_n     (arst_n),
		.touch_en   (touch_en),
		.touch_addr (touch_addr),
		.mark_lo    (mark_lo),
		.mark_hi    (mark_hi)
	);

	assign low_wide = TbmAddrBitsMax'(mark_lo);
	assign high_wide = TbmAddrBitsMax'(mark_hi);
	assign span = high_wide[15:0] - low_wide[15:0] + 16'd1;
	assign res_take = res_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_data_q <= {span, high_wide[15:0], low_wide[15:0], res_rdata};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

// ===== sim/tb_tracked_byte_memory.sv =====
module tb_tracked_byte_memory;
	import tbm_pkg::*;

	localparam int unsigned CycleLimit = 3000000;
	localparam int unsigned RandomItems = 1200;
	localparam int unsigned SteadyBlock = 50;
	localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
	localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

	typedef struct packed {
		logic [31:0] read_data;
		logic [15:0] mark_lo;
		logic [15:0] mark_hi;
		logic [15:0] touched_span;
	} mem_result_t;

	class mem_scoreboard;
		logic [7:0] store [0:65535];
		logic [15:0] mark_lo;
		logic [15:0] mark_hi;
		mem_result_t expected_q[$];
		int unsigned errors;
		int unsigned checked;

		function new();
			foreach (store[i]) store[i] = 8'h00;
			mark_lo = 16'hFFFF;
			mark_hi = 16'h0000;
			errors = 0;
			checked = 0;
		endfunction

		function void touch(logic [15:0] a);
			if (a < mark_lo) mark_lo = a;
			if (a > mark_hi) mark_hi = a;
		endfunction

		function void put_bytes(logic [15:0] a, int unsigned size, logic [31:0] value);
			logic [15:0] p;
			for (int unsigned k = 0; k < size; k++) begin
				p = a + 16'(k);
				touch(p);
				store[p] = value[8*k +: 8];
			end
		endfunction

		function void note_request(logic [3:0] kind, logic [15:0] addr, logic [31:0] value,
				logic [15:0] count);
			mem_result_t r;
			int unsigned size;
			logic [15:0] p;
			r = '0;
			case (kind)
				KIND_RD_WORD, KIND_WR_WORD, KIND_FL_WORD: size = 2;
				KIND_RD_DWORD, KIND_WR_DWORD, KIND_FL_DWORD: size = 4;
				default: size = 1;
			endcase
			case (kind)
				KIND_RD_BYTE, KIND_RD_WORD, KIND_RD_DWORD: begin
					for (int unsigned k = 0; k < size; k++) begin
						p = addr + 16'(k);
						touch(p);
						r.read_data[8*k +: 8] = store[p];
					end
				end
				KIND_WR_BYTE, KIND_WR_WORD, KIND_WR_DWORD: begin
					put_bytes(addr, size, value);
				end
				KIND_FL_BYTE, KIND_FL_WORD, KIND_FL_DWORD: begin
					for (int unsigned e = 0; e < count; e++)
						put_bytes(addr + 16'(e * size), size, value);
				end
				default: ;
			endcase
			r.mark_lo = mark_lo;
			r.mark_hi = mark_hi;
			r.touched_span = mark_hi - mark_lo + 16'd1;
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s expected %h actual %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [79:0] data);
			mem_result_t want;
			if (expected_q.size() == 0) begin
				$error("result %h arrived with no request outstanding", data);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			compare_field("read_data", want.read_data, data[31:0]);
			compare_field("mark_lo", 32'(want.mark_lo), 32'(data[47:32]));
			compare_field("mark_hi", 32'(want.mark_hi), 32'(data[63:48]));
			compare_field("touched_span", 32'(want.touched_span), 32'(data[79:64]));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// address[15:0], write_value[47:16], fill_count[63:48]
	logic [63:0] s_axis_tdata;
	// kind[3:0]
	logic [3:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// read_data[31:0], mark_lo[47:32], mark_hi[63:48], touched_span[79:64]
	logic [79:0] m_axis_tdata;

	mem_scoreboard sb;
	bit steady;
	bit long_hold_done;
	int unsigned sent;
	int unsigned cycle_count;

	tracked_byte_memory dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_request(logic [3:0] kind, logic [15:0] addr, logic [31:0] value,
			logic [15:0] count);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {count, value, addr};
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(kind, addr, value, count);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic send_random(int phase);
		logic [3:0] kind;
		logic [15:0] addr;
		logic [15:0] count;
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 8)
			kind = 4'($urandom_range(int'(KIND_UNUSED_LO), int'(KIND_UNUSED_HI)));
		else
			kind = 4'($urandom_range(int'(KIND_RD_BYTE), int'(KIND_FL_DWORD)));
		count = 16'($urandom);
		if (kind inside {KIND_FL_BYTE, KIND_FL_WORD, KIND_FL_DWORD}) begin
			p = $urandom_range(0, 99);
			if (p < 5)
				count = 16'd0;
			else if (p < 97)
				count = 16'($urandom_range(1, 48));
			else
				count = 16'($urandom_range(49, 4096));
		end
		p = $urandom_range(0, 99);
		if (phase == 1)
			addr = (p < 90) ? 16'h7F00 + 16'($urandom_range(0, 511))
				: 16'($urandom_range(16'h0100, 16'hFEFF));
		else if (p < 35)
			addr = 16'hFFC0 + 16'($urandom_range(0, 63));
		else if (p < 65)
			addr = 16'($urandom_range(0, 63));
		else
			addr = 16'($urandom);
		send_request(kind, addr, $urandom, count);
	endtask

	initial begin
		int unsigned gap;
		m_axis_tready = 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!long_hold_done && sb.checked >= 200) begin
				long_hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (500) @(negedge clk);
			end else begin
				gap = steady ? 0 : $urandom_range(0, 13);
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata);
			@(negedge clk);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("run did not finish within %0d cycles", CycleLimit);
		$display("tracked_byte_memory: mismatch");
		$finish;
	end

	initial begin
		sb = new();
		sent = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(KIND_UNUSED_LO, 16'h1234, 32'h0000_0000, 16'd0);
		send_request(KIND_FL_BYTE, 16'h2000, 32'h0000_00AA, 16'd0);
		send_request(KIND_RD_BYTE, 16'h1234, 32'h0, 16'd0);
		send_request(KIND_WR_BYTE, 16'h1234, 32'h0000_00A5, 16'd0);
		send_request(KIND_RD_BYTE, 16'h1234, 32'h0, 16'd0);
		send_request(KIND_WR_WORD, 16'h1300, 32'h0000_BEEF, 16'd0);
		send_request(KIND_RD_WORD, 16'h1300, 32'h0, 16'd0);
		send_request(KIND_WR_DWORD, 16'h1400, 32'hDEAD_BEEF, 16'd0);
		send_request(KIND_RD_DWORD, 16'h1400, 32'h0, 16'd0);
		send_request(KIND_RD_DWORD, 16'h12FE, 32'h0, 16'd0);
		send_request(KIND_FL_BYTE, 16'h1500, 32'h0000_0077, 16'd5);
		send_request(KIND_FL_WORD, 16'h1600, 32'h0000_1234, 16'd3);
		send_request(KIND_FL_DWORD, 16'h1700, 32'hCAFE_F00D, 16'd4);
		send_request(KIND_RD_DWORD, 16'h1704, 32'h0, 16'd0);
		send_request(KIND_RD_WORD, 16'h1602, 32'h0, 16'd0);
		send_request(KIND_UNUSED_HI, 16'h1500, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(KIND_FL_WORD, 16'h1800, 32'hFFFF_FFFF, 16'd0);
		wait_drained();

		for (int i = 0; i < RandomItems / 2; i++) begin
			if (i % SteadyBlock == 0) steady = ($urandom_range(0, 3) == 0);
			send_random(1);
		end
		steady = 1'b0;
		wait_drained();

		send_request(KIND_WR_DWORD, 16'hFFFE, 32'h1122_3344, 16'd0);
		send_request(KIND_RD_DWORD, 16'hFFFE, 32'h0, 16'd0);
		send_request(KIND_RD_BYTE, 16'h0000, 32'h0, 16'd0);
		send_request(KIND_RD_BYTE, 16'hFFFF, 32'h0, 16'd0);
		send_request(KIND_FL_DWORD, 16'hFFFC, 32'hFFFF_FFFF, 16'd3);
		send_request(KIND_RD_DWORD, 16'h0002, 32'h0, 16'd0);
		send_request(KIND_FL_BYTE, 16'h0001, 32'h0000_005A, 16'hFFFF);
		send_request(KIND_RD_DWORD, 16'hFFFD, 32'h0, 16'd0);
		wait_drained();

		for (int i = 0; i < RandomItems / 2; i++) begin
			if (i % SteadyBlock == 0) steady = ($urandom_range(0, 3) == 0);
			send_random(2);
		end
		steady = 1'b0;
		wait_drained();
		repeat (16) @(negedge clk);

		$display("Sent %0d requests and checked %0d results in %0d cycles.",
			sent, sb.checked, cycle_count);
		$display("Reads, writes and fills of every width, unused kinds, wrapping accesses,");
		$display("a full-store fill and a long output stall were exercised.");
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tracked_byte_memory: match");
		end else begin
			$display("tracked_byte_memory: mismatch");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/tbm_pkg.sv
src/tbm_store.sv
src/tbm_marks.sv
src/tbm_ctrl.sv
src/tracked_byte_memory.sv
sim/tb_tracked_byte_memory.sv
